@@ design/rsc_pkg.sv @@
// Shared types, codes and sizes for the RPN stack calculator.
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int DATA_W          = 32;
  localparam int ENTRY_W         = DATA_W + 1;
  localparam int BOOL_BIT        = DATA_W;
  localparam int ACT_W           = 5;
  localparam int STATUS_W        = 3;
  localparam int DEPTH_OUT_W     = 7;
  localparam int STACK_DEPTH_DEF = 64;

  // Command codes carried by the action field
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_INT   = 5'd0,
    ACT_PUSH_TRUE  = 5'd1,
    ACT_PUSH_FALSE = 5'd2,
    ACT_NOT        = 5'd3,
    ACT_DROP       = 5'd4,
    ACT_DUP        = 5'd5,
    ACT_SWAP       = 5'd6,
    ACT_CLEAR      = 5'd7,
    ACT_ADD        = 5'd8,
    ACT_SUB        = 5'd9,
    ACT_MUL        = 5'd10,
    ACT_DIV        = 5'd11,
    ACT_MOD        = 5'd12,
    ACT_LT         = 5'd13,
    ACT_LE         = 5'd14,
    ACT_GT         = 5'd15,
    ACT_GE         = 5'd16,
    ACT_EQ         = 5'd17,
    ACT_PRINT      = 5'd18
  } act_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOT_BOOL = 3'd2,
    ST_NOT_INT  = 3'd3,
    ST_DIV_ZERO = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // Stack write address relative to the entry count
  typedef enum logic [1:0] {
    WA_PUSH   = 2'd0,  // count
    WA_TOP    = 2'd1,  // count - 1
    WA_SECOND = 2'd2   // count - 2
  } wr_addr_t;

  // Stack write data source
  typedef enum logic [2:0] {
    WD_PUSH  = 3'd0,
    WD_TRUE  = 3'd1,
    WD_FALSE = 3'd2,
    WD_NOT   = 3'd3,
    WD_R     = 3'd4,
    WD_L     = 3'd5,
    WD_ALU   = 3'd6
  } wr_data_t;

  // Entry count update
  typedef enum logic [2:0] {
    CNT_HOLD = 3'd0,
    CNT_INC  = 3'd1,
    CNT_DEC  = 3'd2,
    CNT_DEC2 = 3'd3,
    CNT_CLR  = 3'd4
  } cnt_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             ld_cmd;
    logic             rd_second;
    logic             ld_r;
    logic             ld_l;
    logic             wr_en;
    wr_addr_t         wr_addr;
    wr_data_t         wr_data;
    cnt_op_t          cnt_op;
    logic [ACT_W-1:0] alu_op;
    logic             div_start;
    logic             out_ld;
    status_t          status;
    logic             print;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_full;
    logic r_bool;
    logic l_bool;
    logic r_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/rsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = rsc_pkg::ENTRY_W,
  parameter int DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rsc_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module rsc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rsc_pkg::DATA_W-1:0] dividend,
  input  logic [rsc_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [rsc_pkg::DATA_W-1:0] quotient,
  output logic [rsc_pkg::DATA_W-1:0] remainder
);

  localparam int W    = rsc_pkg::DATA_W;
  localparam int CNTW = $clog2(W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]    quo;
  logic [W-1:0]    rem;
  logic [W-1:0]    dvs;
  logic            neg_q;
  logic            neg_r;
  logic [W-1:0]    abs_dividend;
  logic [W-1:0]    abs_divisor;
  logic [W:0]      sh;
  logic [W+1:0]    diff;

  // Magnitudes of the operands
  assign abs_dividend = dividend[W-1] ? (~dividend + W'(1)) : dividend;
  assign abs_divisor  = divisor[W-1]  ? (~divisor + W'(1))  : divisor;

  // Trial subtract of the shifted partial remainder
  assign sh   = {rem, quo[W-1]};
  assign diff = {1'b0, sh} - {2'b00, dvs};

  // Control: count down one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring shift-subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= abs_dividend;
      rem   <= '0;
      dvs   <= abs_divisor;
      neg_q <= dividend[W-1] ^ divisor[W-1];
      neg_r <= dividend[W-1];
    end else if (busy) begin
      if (!diff[W+1]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  // Apply signs
  assign quotient  = neg_q ? (~quo + W'(1)) : quo;
  assign remainder = neg_r ? (~rem + W'(1)) : rem;

endmodule

@@ design/rsc_dpath.sv @@
// Datapath: stack memory, entry count, operand registers, ALU, divider, result register.
`timescale 1ns / 1ps

module rsc_dpath #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rsc_pkg::dp_cmd_t                cmd,
  output rsc_pkg::dp_stat_t               stat,
  input  logic signed [rsc_pkg::DATA_W-1:0] push_value,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [rsc_pkg::STATUS_W-1:0]    status,
  output logic                            print_valid,
  output logic                            print_is_bool,
  output logic signed [rsc_pkg::DATA_W-1:0] print_value,
  output logic [rsc_pkg::DEPTH_OUT_W-1:0] stack_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = rsc_pkg::DATA_W;
  localparam int EW = rsc_pkg::ENTRY_W;
  localparam int BB = rsc_pkg::BOOL_BIT;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [DW-1:0] push_val;
  logic [EW-1:0] op_r;
  logic [EW-1:0] op_l;

  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  logic [DW-1:0] l_val;
  logic [DW-1:0] r_val;
  logic [DW-1:0] mul_res;
  logic [EW-1:0] alu_res;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [DW-1:0] div_r;

  assign l_val = op_l[DW-1:0];
  assign r_val = op_r[DW-1:0];

  // Stack storage
  rsc_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Divide and mod unit
  rsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (l_val),
    .divisor   (r_val),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Read the top entry, or the one below it
  assign raddr = cmd.rd_second ? AW'(count - CW'(2)) : AW'(count - CW'(1));

  // Pick the write address
  always_comb begin
    unique case (cmd.wr_addr)
      rsc_pkg::WA_PUSH:   waddr = AW'(count);
      rsc_pkg::WA_TOP:    waddr = AW'(count - CW'(1));
      rsc_pkg::WA_SECOND: waddr = AW'(count - CW'(2));
      default:            waddr = AW'(count);
    endcase
  end

  // Arithmetic and comparisons
  assign mul_res = l_val * r_val;

  always_comb begin
    unique case (cmd.alu_op)
      rsc_pkg::ACT_ADD: alu_res = {1'b0, l_val + r_val};
      rsc_pkg::ACT_SUB: alu_res = {1'b0, l_val - r_val};
      rsc_pkg::ACT_MUL: alu_res = {1'b0, mul_res};
      rsc_pkg::ACT_DIV: alu_res = {1'b0, div_q};
      rsc_pkg::ACT_MOD: alu_res = {1'b0, div_r};
      rsc_pkg::ACT_LT:  alu_res = {1'b1, (DW-1)'(0), $signed(l_val) <  $signed(r_val)};
      rsc_pkg::ACT_LE:  alu_res = {1'b1, (DW-1)'(0), $signed(l_val) <= $signed(r_val)};
      rsc_pkg::ACT_GT:  alu_res = {1'b1, (DW-1)'(0), $signed(l_val) >  $signed(r_val)};
      rsc_pkg::ACT_GE:  alu_res = {1'b1, (DW-1)'(0), $signed(l_val) >= $signed(r_val)};
      rsc_pkg::ACT_EQ:  alu_res = {1'b1, (DW-1)'(0), l_val == r_val};
      default:          alu_res = '0;
    endcase
  end

  // Pick the write data
  always_comb begin
    unique case (cmd.wr_data)
      rsc_pkg::WD_PUSH:  wdata = {1'b0, push_val};
      rsc_pkg::WD_TRUE:  wdata = {1'b1, DW'(1)};
      rsc_pkg::WD_FALSE: wdata = {1'b1, DW'(0)};
      rsc_pkg::WD_NOT:   wdata = {1'b1, (DW-1)'(0), ~|r_val};
      rsc_pkg::WD_R:     wdata = op_r;
      rsc_pkg::WD_L:     wdata = op_l;
      rsc_pkg::WD_ALU:   wdata = alu_res;
      default:           wdata = op_r;
    endcase
  end

  // Entry count update
  always_comb begin
    unique case (cmd.cnt_op)
      rsc_pkg::CNT_HOLD: count_next = count;
      rsc_pkg::CNT_INC:  count_next = count + CW'(1);
      rsc_pkg::CNT_DEC:  count_next = count - CW'(1);
      rsc_pkg::CNT_DEC2: count_next = count - CW'(2);
      rsc_pkg::CNT_CLR:  count_next = '0;
      default:           count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Capture the transaction payload and the operands
  always_ff @(posedge clk) begin
    if (cmd.ld_cmd) begin
      push_val <= push_value;
    end
    if (cmd.ld_r) begin
      op_r <= rdata;
    end
    if (cmd.ld_l) begin
      op_l <= rdata;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      status        <= cmd.status;
      print_valid   <= cmd.print;
      print_is_bool <= cmd.print & op_r[BB];
      print_value   <= cmd.print ? r_val : '0;
      stack_depth   <= rsc_pkg::DEPTH_OUT_W'(count_next);
    end
  end

  // Status back to the controller
  assign stat.cnt_zero = (count == '0);
  assign stat.cnt_lt2  = (count < CW'(2));
  assign stat.cnt_full = (count == CW'(STACK_DEPTH));
  assign stat.r_bool   = op_r[BB];
  assign stat.l_bool   = op_l[BB];
  assign stat.r_zero   = (r_val == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

@@ design/rsc_ctrl.sv @@
// Controller: sequences operand reads, command decode, divide wait and result hand-off.
`timescale 1ns / 1ps

module rsc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rsc_pkg::ACT_W-1:0] action,
  input  rsc_pkg::dp_stat_t         stat,
  output rsc_pkg::dp_cmd_t          cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RDNEXT  = 7'b0000010,
    S_LOAD    = 7'b0000100,
    S_EXEC    = 7'b0001000,
    S_SWAP2   = 7'b0010000,
    S_DIVWAIT = 7'b0100000,
    S_FINDIV  = 7'b1000000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [rsc_pkg::ACT_W-1:0] act_q;

  // Decoded outcome of the current command
  rsc_pkg::status_t  ex_status;
  logic              ex_wr;
  rsc_pkg::wr_addr_t ex_wa;
  rsc_pkg::wr_data_t ex_wd;
  rsc_pkg::cnt_op_t  ex_cnt;
  logic              ex_print;
  logic              ex_div;
  logic              ex_swap;

  // Hold the command code of the accepted transaction
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act_q <= action;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode the command against the stack status
  always_comb begin
    ex_status = rsc_pkg::ST_OK;
    ex_wr     = 1'b0;
    ex_wa     = rsc_pkg::WA_PUSH;
    ex_wd     = rsc_pkg::WD_PUSH;
    ex_cnt    = rsc_pkg::CNT_HOLD;
    ex_print  = 1'b0;
    ex_div    = 1'b0;
    ex_swap   = 1'b0;
    unique case (act_q)
      rsc_pkg::ACT_PUSH_INT, rsc_pkg::ACT_PUSH_TRUE, rsc_pkg::ACT_PUSH_FALSE: begin
        if (stat.cnt_full) begin
          ex_status = rsc_pkg::ST_FULL;
        end else begin
          ex_wr  = 1'b1;
          ex_cnt = rsc_pkg::CNT_INC;
          if (act_q == rsc_pkg::ACT_PUSH_TRUE) begin
            ex_wd = rsc_pkg::WD_TRUE;
          end else if (act_q == rsc_pkg::ACT_PUSH_FALSE) begin
            ex_wd = rsc_pkg::WD_FALSE;
          end
        end
      end
      rsc_pkg::ACT_NOT: begin
        if (stat.cnt_zero) begin
          ex_status = rsc_pkg::ST_EMPTY;
        end else if (!stat.r_bool) begin
          ex_status = rsc_pkg::ST_NOT_BOOL;
          ex_cnt    = rsc_pkg::CNT_DEC;
        end else begin
          ex_wr = 1'b1;
          ex_wa = rsc_pkg::WA_TOP;
          ex_wd = rsc_pkg::WD_NOT;
        end
      end
      rsc_pkg::ACT_DROP: begin
        if (stat.cnt_zero) begin
          ex_status = rsc_pkg::ST_EMPTY;
        end else begin
          ex_cnt = rsc_pkg::CNT_DEC;
        end
      end
      rsc_pkg::ACT_DUP: begin
        if (stat.cnt_zero) begin
          ex_status = rsc_pkg::ST_EMPTY;
        end else if (stat.cnt_full) begin
          ex_status = rsc_pkg::ST_FULL;
        end else begin
          ex_wr  = 1'b1;
          ex_wd  = rsc_pkg::WD_R;
          ex_cnt = rsc_pkg::CNT_INC;
        end
      end
      rsc_pkg::ACT_SWAP: begin
        if (stat.cnt_lt2) begin
          ex_status = rsc_pkg::ST_EMPTY;
        end else begin
          ex_swap = 1'b1;
          ex_wr   = 1'b1;
          ex_wa   = rsc_pkg::WA_TOP;
          ex_wd   = rsc_pkg::WD_L;
        end
      end
      rsc_pkg::ACT_CLEAR: begin
        ex_cnt = rsc_pkg::CNT_CLR;
      end
      rsc_pkg::ACT_ADD, rsc_pkg::ACT_SUB, rsc_pkg::ACT_MUL, rsc_pkg::ACT_DIV,
      rsc_pkg::ACT_MOD, rsc_pkg::ACT_LT, rsc_pkg::ACT_LE, rsc_pkg::ACT_GT,
      rsc_pkg::ACT_GE, rsc_pkg::ACT_EQ: begin
        if (stat.cnt_lt2) begin
          ex_status = rsc_pkg::ST_EMPTY;
        end else if (stat.r_bool || stat.l_bool) begin
          ex_status = rsc_pkg::ST_NOT_INT;
          ex_cnt    = rsc_pkg::CNT_DEC2;
        end else if (act_q == rsc_pkg::ACT_DIV || act_q == rsc_pkg::ACT_MOD) begin
          if (stat.r_zero) begin
            ex_status = rsc_pkg::ST_DIV_ZERO;
            ex_cnt    = rsc_pkg::CNT_DEC2;
          end else begin
            ex_div = 1'b1;
          end
        end else begin
          ex_wr  = 1'b1;
          ex_wa  = rsc_pkg::WA_SECOND;
          ex_wd  = rsc_pkg::WD_ALU;
          ex_cnt = rsc_pkg::CNT_DEC;
        end
      end
      rsc_pkg::ACT_PRINT: begin
        if (stat.cnt_zero) begin
          ex_status = rsc_pkg::ST_EMPTY;
        end else begin
          ex_print = 1'b1;
        end
      end
      default: begin
        ex_status = rsc_pkg::ST_OK;
      end
    endcase
  end

  // Sequence the steps and drive the datapath
  always_comb begin
    cmd        = '0;
    cmd.alu_op = act_q;
    state_next = state;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_cmd = 1'b1;
          state_next = S_RDNEXT;
        end
      end
      S_RDNEXT: begin
        cmd.ld_r      = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_LOAD;
      end
      S_LOAD: begin
        cmd.ld_l   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (ex_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVWAIT;
        end else if (ex_swap) begin
          cmd.wr_en   = ex_wr;
          cmd.wr_addr = ex_wa;
          cmd.wr_data = ex_wd;
          state_next  = S_SWAP2;
        end else if (stat.out_free) begin
          cmd.wr_en   = ex_wr;
          cmd.wr_addr = ex_wa;
          cmd.wr_data = ex_wd;
          cmd.cnt_op  = ex_cnt;
          cmd.out_ld  = 1'b1;
          cmd.status  = ex_status;
          cmd.print   = ex_print;
          state_next  = S_IDLE;
        end
      end
      S_SWAP2: begin
        if (stat.out_free) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = rsc_pkg::WA_SECOND;
          cmd.wr_data = rsc_pkg::WD_R;
          cmd.out_ld  = 1'b1;
          cmd.status  = rsc_pkg::ST_OK;
          state_next  = S_IDLE;
        end
      end
      S_DIVWAIT: begin
        if (stat.div_done) begin
          state_next = S_FINDIV;
        end
      end
      S_FINDIV: begin
        if (stat.out_free) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = rsc_pkg::WA_SECOND;
          cmd.wr_data = rsc_pkg::WD_ALU;
          cmd.cnt_op  = rsc_pkg::CNT_DEC;
          cmd.out_ld  = 1'b1;
          cmd.status  = rsc_pkg::ST_OK;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/rpn_stack_calculator_top.sv @@
// Top level of the typed RPN stack calculator: controller plus datapath.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+----------------------------------------------
//  in       | in_valid / in_stall | action, push_value
//  out      | out_valid/out_stall | status, print_valid, print_is_bool,
//           |                     | print_value, stack_depth
//
// Commands run RDNEXT, LOAD, EXEC (swap adds SWAP2; div/mod DIVWAIT, FINDIV);
// the stack memory's single read port fetches the top and second entries in
// turn, and div/mod run a 32-step shift-subtract divider.
// A new command is accepted once the previous result is in the output register.
// A stalled output holds the block in its final step; nothing is dropped.
// Synchronous reset empties the stack; stack contents are not cleared.
`timescale 1ns / 1ps

module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rsc_pkg::ACT_W-1:0]         action,
  input  logic signed [rsc_pkg::DATA_W-1:0] push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rsc_pkg::STATUS_W-1:0]      status,
  output logic                              print_valid,
  output logic                              print_is_bool,
  output logic signed [rsc_pkg::DATA_W-1:0] print_value,
  output logic [rsc_pkg::DEPTH_OUT_W-1:0]   stack_depth
);

  rsc_pkg::dp_cmd_t  cmd;
  rsc_pkg::dp_stat_t stat;

  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsc_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .push_value    (push_value),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .print_valid   (print_valid),
    .print_is_bool (print_is_bool),
    .print_value   (print_value),
    .stack_depth   (stack_depth)
  );

endmodule
